// ===== rtl/mstq_pkg.sv =====
// Package for the multi-slot timer queue: command and result codes, state and cell control types.
`default_nettype none
package mstq_pkg;

   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_CANCEL   = 2'd1,
      CMD_FIRE     = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_SCHED_ACK  = 2'd0,
      KIND_CANCEL_ACK = 2'd1,
      KIND_FIRED      = 2'd2,
      KIND_NONE_DUE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic write;
      logic clear;
      logic reload;
      logic latch;
   } cell_ctl_type;

   localparam int unsigned TIME_BITS = 32;
   localparam int unsigned OUT_ID_BITS = 16;

endpackage
`default_nettype wire

// ===== rtl/mstq_cell.sv =====
// One timer slot of the chain: holds a timer and passes free/match priority to its neighbor.
`default_nettype none
module mstq_cell #(
   parameter int ID_BITS = 16,
   parameter int IDW = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire mstq_pkg::cell_ctl_type    ctl,
   input  wire [mstq_pkg::TIME_BITS-1:0]  now,
   input  wire [mstq_pkg::TIME_BITS-1:0]  delay,
   input  wire                            rep,
   input  wire [ID_BITS-1:0]              new_id,
   input  wire [IDW-1:0]                  target,
   input  wire                            free_in,
   output logic                           free_out,
   input  wire                            hit_in,
   output logic                           hit_out,
   output logic                           free_pick,
   output logic                           hit_pick,
   output logic                           due_now,
   output logic                           pend,
   output logic                           repeat_out,
   output logic [ID_BITS-1:0]             id
);
   import mstq_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 pend_ff, pend_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic                 rep_ff, rep_in;
   logic                 match;

   assign match     = valid_ff && (IDW'(id_ff) == target);
   assign free_pick = !valid_ff && !free_in;
   assign free_out  = free_in || !valid_ff;
   assign hit_pick  = match && !hit_in;
   assign hit_out   = hit_in || match;
   assign due_now   = valid_ff && (due_ff <= now);
   assign pend      = pend_ff;
   assign repeat_out = rep_ff;
   assign id        = id_ff;

   always_comb begin
      valid_in  = valid_ff;
      pend_in   = pend_ff;
      id_in     = id_ff;
      due_in    = due_ff;
      period_in = period_ff;
      rep_in    = rep_ff;
      if (ctl.write) begin
         valid_in  = 1'b1;
         pend_in   = 1'b0;
         id_in     = new_id;
         due_in    = now + delay;
         period_in = delay;
         rep_in    = rep;
      end else if (ctl.clear) begin
         valid_in = 1'b0;
         pend_in  = 1'b0;
      end else if (ctl.reload) begin
         pend_in = 1'b0;
         due_in  = now + period_ff;
      end else if (ctl.latch) begin
         pend_in = due_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      id_ff     <= id_in;
      due_ff    <= due_in;
      period_ff <= period_in;
      rep_ff    <= rep_in;
   end

endmodule
`default_nettype wire

// ===== rtl/multi_slot_timer_queue.sv =====
// Top level of the multi-slot timer queue: command sequencer, row of slot cells, result register.
// Usage:
//   Requests enter on req_* (valid/stall); results leave on rsp_* (valid/stall),
//   one registered result at a time, rsp_last marking the final result of a request.
//   Schedule and cancel finish in the accept cycle: their single result appears
//   the next cycle. Free-slot and id-match priority ripple through the cell row.
//   Fire latches every slot's due flag at accept. Each fired timer then takes a
//   scan of all SLOTS cells, one cell per cycle, to find the lowest pending id,
//   and an emit step, which waits while the result register is full, to emit it
//   and reload or free its slot. With none due a fire gives one none-due result
//   right away. Command 3 is taken and gives nothing.
//   One request is handled at a time; req_stall is high while a fire is running
//   or while the result register is full and rsp_stall is high.
//   A stalled result holds its value and blocks new requests and further emits.
//   Reset clears all slot valid flags, the id counter and the result register.
`default_nettype none
module multi_slot_timer_queue #(
   parameter int SLOTS = 16,
   parameter int ID_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_command,
   input  wire  [31:0] req_now_ms,
   input  wire  [31:0] req_delay_ms,
   input  wire         req_repeat_flag,
   input  wire  [15:0] req_target_id,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_timer_id,
   output logic        rsp_ok,
   output logic        rsp_last
);
   import mstq_pkg::*;

   localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW  = $clog2(SLOTS + 1);
   localparam int IDW = (ID_BITS > OUT_ID_BITS) ? ID_BITS : OUT_ID_BITS;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff, kind_in;
   logic [15:0]          tid_ff, tid_in;
   logic                 ok_ff, ok_in;
   logic                 last_ff, last_in;
   logic [ID_BITS-1:0]   idc_ff, idc_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [IW-1:0]        scan_ff, scan_in;
   logic [IW-1:0]        best_ff, best_in;
   logic [ID_BITS-1:0]   best_id_ff, best_id_in;
   logic                 best_rep_ff, best_rep_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   cell_ctl_type         ctl [SLOTS];
   logic [SLOTS:0]       free_chain, hit_chain;
   logic [SLOTS-1:0]     free_pick, hit_pick, due_now, pend, rep_v;
   logic [ID_BITS-1:0]   cell_id [SLOTS];
   logic [TIME_BITS-1:0] cell_now;
   logic [IDW-1:0]       target;
   logic                 out_free, accept;
   cmd_type              cmd;
   logic [IW-1:0]        free_idx, hit_idx;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_command);
   assign cell_now  = (state_ff == ST_IDLE) ? req_now_ms : now_ff;
   assign target    = IDW'(req_target_id);
   assign free_chain[0] = 1'b0;
   assign hit_chain[0]  = 1'b0;

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         mstq_cell #(.ID_BITS(ID_BITS), .IDW(IDW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl[g]),
            .now        (cell_now),
            .delay      (req_delay_ms),
            .rep        (req_repeat_flag),
            .new_id     (idc_ff),
            .target     (target),
            .free_in    (free_chain[g]),
            .free_out   (free_chain[g+1]),
            .hit_in     (hit_chain[g]),
            .hit_out    (hit_chain[g+1]),
            .free_pick  (free_pick[g]),
            .hit_pick   (hit_pick[g]),
            .due_now    (due_now[g]),
            .pend       (pend[g]),
            .repeat_out (rep_v[g]),
            .id         (cell_id[g])
         );
      end
   endgenerate

   always_comb begin
      free_idx = '0;
      hit_idx  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (free_pick[i]) free_idx = IW'(i);
         if (hit_pick[i])  hit_idx  = IW'(i);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      tid_in       = tid_ff;
      ok_in        = ok_ff;
      last_in      = last_ff;
      idc_in       = idc_ff;
      now_in       = now_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      best_rep_in  = best_rep_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      for (int i = 0; i < SLOTS; i++) ctl[i] = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_SCHEDULE: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_SCHED_ACK;
                     last_in      = 1'b1;
                     ok_in        = free_chain[SLOTS];
                     tid_in       = '0;
                     if (free_chain[SLOTS]) begin
                        ctl[free_idx].write = 1'b1;
                        tid_in = 16'(IDW'(idc_ff));
                        idc_in = idc_ff + 1'b1;
                     end
                  end
                  CMD_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_CANCEL_ACK;
                     last_in      = 1'b1;
                     ok_in        = hit_chain[SLOTS];
                     tid_in       = req_target_id;
                     if (hit_chain[SLOTS]) ctl[hit_idx].clear = 1'b1;
                  end
                  CMD_FIRE: begin
                     for (int i = 0; i < SLOTS; i++) ctl[i].latch = 1'b1;
                     now_in = req_now_ms;
                     cnt_in = CW'($countones(due_now));
                     if (due_now == '0) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_NONE_DUE;
                        tid_in       = '0;
                        ok_in        = 1'b0;
                        last_in      = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                        scan_in  = '0;
                        found_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (pend[scan_ff] && (!found_ff || cell_id[scan_ff] < best_id_ff)) begin
               found_in    = 1'b1;
               best_in     = scan_ff;
               best_id_in  = cell_id[scan_ff];
               best_rep_in = rep_v[scan_ff];
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IW'(SLOTS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_FIRED;
               tid_in       = 16'(IDW'(best_id_ff));
               ok_in        = 1'b1;
               last_in      = (cnt_ff == CW'(1));
               if (best_rep_ff) ctl[best_ff].reload = 1'b1;
               else             ctl[best_ff].clear  = 1'b1;
               cnt_in   = cnt_ff - 1'b1;
               scan_in  = '0;
               found_in = 1'b0;
               state_in = (cnt_ff == CW'(1)) ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idc_ff       <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idc_ff       <= idc_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
      end
      kind_ff     <= kind_in;
      tid_ff      <= tid_in;
      ok_ff       <= ok_in;
      last_ff     <= last_in;
      now_ff      <= now_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      best_id_ff  <= best_id_in;
      best_rep_ff <= best_rep_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_timer_id    = tid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_last        = last_ff;

   a_free_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(free_pick)) else $error("more than one free slot picked");
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_pick)) else $error("more than one cancel match picked");
   a_cnt_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_EMIT) |-> (CW'($countones(pend)) == cnt_ff))
      else $error("pending count out of step with pending flags");
   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (found_ff && pend[best_ff]))
      else $error("emit without a pending timer");

endmodule
`default_nettype wire

// ===== bench/multi_slot_timer_queue_tb.sv =====
// Testbench for the multi-slot timer queue: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module multi_slot_timer_queue_tb;
   import mstq_pkg::*;

   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASE_ITEMS = 80;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] now_ms;
      logic [31:0] delay_ms;
      logic        repeat_flag;
      logic [15:0] target_id;
   } request_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] timer_id;
      logic        ok;
      logic        last;
   } result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_NOP;
   logic [31:0] req_now_ms = 0;
   logic [31:0] req_delay_ms = 0;
   logic        req_repeat_flag = 0;
   logic [15:0] req_target_id = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_timer_id;
   logic        rsp_ok;
   logic        rsp_last;

   multi_slot_timer_queue i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_now_ms(req_now_ms),
      .req_delay_ms(req_delay_ms), .req_repeat_flag(req_repeat_flag),
      .req_target_id(req_target_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_timer_id(rsp_timer_id),
      .rsp_ok(rsp_ok), .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   // predictor state
   logic        tmr_live[NSLOT] = '{default: 1'b0};
   logic [15:0] tmr_id[NSLOT];
   logic [31:0] tmr_due[NSLOT];
   logic [31:0] tmr_period[NSLOT];
   logic        tmr_repeat[NSLOT];
   logic [15:0] next_id = 16'd0;

   request_type pending_reqs[$];
   result_type  expected_results[$];
   int          errors = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_armed = 0;
   logic        hold_seen = 0;
   int          hold_left = 0;
   logic        req_taken = 0;
   int          issued;

   task automatic add_expected(input result_type res);
      expected_results.insert(expected_results.size(), res);
   endtask

   task automatic predict_timer(input request_type r);
      logic   due[NSLOT];
      int     ndue;
      int     best;
      result_type res;
      ndue = 0;
      case (r.command)
         CMD_SCHEDULE: begin
            res = '{KIND_SCHED_ACK, 16'd0, 1'b0, 1'b1};
            for (int i = 0; i < NSLOT; i++)
               if (!tmr_live[i] && !res.ok) begin
                  tmr_live[i] = 1;
                  tmr_id[i] = next_id;
                  tmr_due[i] = r.now_ms + r.delay_ms;
                  tmr_period[i] = r.delay_ms;
                  tmr_repeat[i] = r.repeat_flag;
                  res.timer_id = next_id;
                  res.ok = 1;
                  next_id++;
               end
            add_expected(res);
         end
         CMD_CANCEL: begin
            res = '{KIND_CANCEL_ACK, r.target_id, 1'b0, 1'b1};
            for (int i = 0; i < NSLOT; i++)
               if (tmr_live[i] && tmr_id[i] == r.target_id && !res.ok) begin
                  tmr_live[i] = 0;
                  res.ok = 1;
               end
            add_expected(res);
         end
         CMD_FIRE: begin
            for (int i = 0; i < NSLOT; i++) begin
               due[i] = tmr_live[i] && tmr_due[i] <= r.now_ms;
               if (due[i]) ndue++;
            end
            if (ndue == 0) begin
               res = '{KIND_NONE_DUE, 16'd0, 1'b0, 1'b1};
               add_expected(res);
            end
            for (int k = 0; k < ndue; k++) begin
               best = -1;
               for (int i = 0; i < NSLOT; i++)
                  if (due[i] && (best < 0 || tmr_id[i] < tmr_id[best])) best = i;
               due[best] = 0;
               if (tmr_repeat[best]) tmr_due[best] = r.now_ms + tmr_period[best];
               else tmr_live[best] = 0;
               res = '{KIND_FIRED, tmr_id[best], 1'b1, k == ndue - 1};
               add_expected(res);
            end
         end
         default: ;
      endcase
   endtask

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_armed && !hold_seen) begin
         hold_seen <= 1;
         hold_left <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // driver
   always @(negedge clock) begin
      request_type r;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_valid <= 1;
               req_command <= r.command;
               req_now_ms <= r.now_ms;
               req_delay_ms <= r.delay_ms;
               req_repeat_flag <= r.repeat_flag;
               req_target_id <= r.target_id;
            end else begin
               req_valid <= 0;
            end
         end
         if (hold_left > 0)
            rsp_stall <= 1;
         else
            rsp_stall <= $urandom_range(99) < recv_stall_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type  got, want;
      request_type acc;
      cycles <= cycles + 1;
      req_taken <= 0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken <= 1;
            acc.command = cmd_type'(req_command);
            acc.now_ms = req_now_ms;
            acc.delay_ms = req_delay_ms;
            acc.repeat_flag = req_repeat_flag;
            acc.target_id = req_target_id;
            predict_timer(acc);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{kind_type'(rsp_result_kind), rsp_timer_id, rsp_ok, rsp_last};
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // plausible recent id, so cancels usually hit
   function automatic logic [15:0] next_guess(input int base);
      return 16'(base - $urandom_range(20));
   endfunction

   function automatic request_type rand_req(input int live_bias);
      request_type r;
      int pick;
      r.now_ms = $urandom_range(3) == 0 ? $urandom : $urandom_range(2000);
      r.delay_ms = $urandom_range(7) == 0 ? $urandom : $urandom_range(300);
      r.repeat_flag = 1'($urandom_range(1));
      r.target_id = $urandom_range(3) == 0 ? 16'($urandom) : next_guess(live_bias);
      pick = $urandom_range(99);
      if (pick < 45) r.command = CMD_SCHEDULE;
      else if (pick < 65) r.command = CMD_CANCEL;
      else if (pick < 97) r.command = CMD_FIRE;
      else r.command = CMD_NOP;
      return r;
   endfunction

   task automatic add_req(input request_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic push_req(input cmd_type c, input logic [31:0] now_v,
                           input logic [31:0] dly, input logic rep,
                           input logic [15:0] tid);
      request_type r;
      r = '{c, now_v, dly, rep, tid};
      add_req(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: fill past capacity, fire, cancel hits and misses, wrap of due
      for (int i = 0; i < 17; i++)
         push_req(CMD_SCHEDULE, 32'd0, i == 0 ? 32'hFFFF_FFFF : 32'(i * 10),
                  i[0], 16'd0);
      push_req(CMD_FIRE, 32'd0, 32'd0, 1'b0, 16'd0);
      push_req(CMD_FIRE, 32'd50, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      push_req(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 16'd3);
      push_req(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 16'hFFFF);
      push_req(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'd2, 1'b1, 16'd0);
      push_req(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      push_req(CMD_FIRE, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
      drain();
      issued = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin send_idle_pct = 79; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 79; end
            3: begin send_idle_pct = 38; recv_stall_pct = 38; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 0) hold_armed = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) add_req(rand_req(17 + issued + n));
         issued += PHASE_ITEMS;
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int n = 0; n < 20; n++) add_req(rand_req(int'(next_id)));
      push_req(CMD_FIRE, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
      drain();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
